[rtl/core/pidc_pkg.sv]
// Shared types and constants for the PID controller with integral clamp.
// Used by pidc_cfg, pidc_mul and pid_with_integral_clamp_unit; no dependencies.
package pidc_pkg;

    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 31;
    localparam int TICK_W   = 16;
    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 31;

    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 33;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int FRAC_W   = 16;
    localparam int SHR_W    = PROD_W - FRAC_W;
    localparam int ERR_W    = 33;
    localparam int ACC_W    = 43;
    localparam int SUM_W    = 43;
    localparam int HI_W     = SUM_W - FRAC_W;
    localparam int DRV_W    = 52;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 3'd4;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 24'sd65536;
    localparam logic [TICK_W-1:0]        TICK_RST   = 16'd655;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIMIT_W-1:0]       integral_limit;
        logic [TICK_W-1:0]        tick_period;
    } t_cfg;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_STEP = 8'b0000_0010,
        ST_INT  = 8'b0000_0100,
        ST_TI   = 8'b0000_1000,
        ST_SUM  = 8'b0001_0000,
        ST_LO   = 8'b0010_0000,
        ST_HI   = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } t_state;

endpackage

[rtl/core/pidc_cfg.sv]
// Configuration register file: gains, integral bound and tick period.
// Depends on pidc_pkg.
module pidc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pidc_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output pidc_pkg::t_cfg                     o_cfg
);

    pidc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= pidc_pkg::GAIN_P_RST;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.integral_limit <= '0;
            r_cfg.tick_period    <= pidc_pkg::TICK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pidc_pkg::CFG_GAIN_P: r_cfg.gain_p <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::CFG_GAIN_I: r_cfg.gain_i <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::CFG_GAIN_D: r_cfg.gain_d <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::CFG_LIMIT:  r_cfg.integral_limit <= i_cfg_data;
                pidc_pkg::CFG_TICK:   r_cfg.tick_period <= i_cfg_data[pidc_pkg::TICK_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/pidc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on pidc_pkg.
module pidc_mul (
    input  logic                                    i_clk,
    input  logic signed [pidc_pkg::MUL_A_W-1:0]     i_op_a,
    input  logic signed [pidc_pkg::MUL_B_W-1:0]     i_op_b,
    output logic signed [pidc_pkg::PROD_W-1:0]      o_prod
);

    logic signed [pidc_pkg::PROD_W-1:0] r_prod;
    logic signed [pidc_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = pidc_pkg::PROD_W'(i_op_a) * pidc_pkg::PROD_W'(i_op_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

[rtl/core/pid_with_integral_clamp_unit.sv]
// PID controller with anti-windup integral clamp: one sample in, one drive out.
// Depends on pidc_pkg, pidc_cfg and pidc_mul.
//
// Each accepted sample runs through the states STEP, INT, TI, SUM, LO, HI and FIN to a loaded result:
// five products go through one shared 25x33 signed multiplier (error times
// tick period, derivative term, integral term, and the outer gain applied to
// the low and high halves of the 43-bit sum), each product registered before
// use, followed by a final add and saturate. The input is not ready while a
// sample is in flight and is ready again only once the sequencer is back in
// idle, so no new sample is taken before the last one is through. A finished
// result sits in an output register, so a new sample can be taken while it
// waits, and the next result only stalls in its last step if the previous one
// is still untaken. All values are Q16.16, gains Q8.16; products are floored
// by an arithmetic shift by 16.
module pid_with_integral_clamp_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pidc_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [pidc_pkg::DATA_W-1:0]    i_measured,
    input  logic signed [pidc_pkg::DATA_W-1:0]    i_measured_rate,
    input  logic signed [pidc_pkg::DATA_W-1:0]    i_reference,
    input  logic signed [pidc_pkg::DATA_W-1:0]    i_reference_rate,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [pidc_pkg::DATA_W-1:0]    o_drive,
    output logic                                  o_drive_saturated
);

    localparam int EXT_W = pidc_pkg::ERR_W - pidc_pkg::DATA_W;

    pidc_pkg::t_cfg  w_cfg;
    pidc_pkg::t_state r_state;
    pidc_pkg::t_state n_state;

    logic signed [pidc_pkg::ERR_W-1:0]   r_err;
    logic signed [pidc_pkg::ERR_W-1:0]   r_err_rate;
    logic signed [pidc_pkg::DATA_W-1:0]  r_integral;
    logic signed [pidc_pkg::SUM_W-1:0]   r_sum;
    logic signed [pidc_pkg::DRV_W-1:0]   r_drv;
    logic                                r_out_valid;
    logic signed [pidc_pkg::DATA_W-1:0]  r_drive;
    logic                                r_drive_sat;

    logic signed [pidc_pkg::MUL_A_W-1:0] w_op_a;
    logic signed [pidc_pkg::MUL_B_W-1:0] w_op_b;
    logic signed [pidc_pkg::PROD_W-1:0]  w_prod;
    logic signed [pidc_pkg::SHR_W-1:0]   w_shr;
    logic signed [pidc_pkg::ACC_W-1:0]   w_acc;
    logic signed [pidc_pkg::ACC_W-1:0]   w_lim;
    logic signed [pidc_pkg::DATA_W-1:0]  w_clamped;
    logic signed [pidc_pkg::DRV_W-1:0]   w_drv_full;
    logic                                w_over;
    logic                                w_in_acc;
    logic                                w_fin_go;

    pidc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pidc_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod)
    );

    assign o_in_ready = (r_state == pidc_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_fin_go   = (r_state == pidc_pkg::ST_FIN) && (!r_out_valid || i_out_ready);

    // product floored by 2^16
    assign w_shr = w_prod[pidc_pkg::PROD_W-1:pidc_pkg::FRAC_W];

    // operand select for the shared multiplier
    always_comb begin
        w_op_a = pidc_pkg::MUL_A_W'(w_cfg.gain_p);
        w_op_b = pidc_pkg::MUL_B_W'({1'b0, r_sum[pidc_pkg::FRAC_W-1:0]});
        case (r_state)
            pidc_pkg::ST_STEP: begin
                w_op_a = pidc_pkg::MUL_A_W'({1'b0, w_cfg.tick_period});
                w_op_b = r_err;
            end
            pidc_pkg::ST_INT: begin
                w_op_a = pidc_pkg::MUL_A_W'(w_cfg.gain_d);
                w_op_b = r_err_rate;
            end
            pidc_pkg::ST_TI: begin
                w_op_a = pidc_pkg::MUL_A_W'(w_cfg.gain_i);
                w_op_b = pidc_pkg::MUL_B_W'(r_integral);
            end
            // hold the high-half operands while the final step waits
            pidc_pkg::ST_HI, pidc_pkg::ST_FIN: begin
                w_op_a = pidc_pkg::MUL_A_W'(w_cfg.gain_p);
                w_op_b = pidc_pkg::MUL_B_W'($signed(r_sum[pidc_pkg::SUM_W-1:pidc_pkg::FRAC_W]));
            end
            default: begin
                // keep the low-half operands
            end
        endcase
    end

    // integral update and clamp
    always_comb begin
        w_acc = pidc_pkg::ACC_W'(r_integral) + pidc_pkg::ACC_W'(w_shr);
        w_lim = pidc_pkg::ACC_W'({1'b0, w_cfg.integral_limit});
        if (w_acc > w_lim) begin
            w_clamped = pidc_pkg::DATA_W'(w_lim);
        end else if (w_acc < -w_lim) begin
            w_clamped = pidc_pkg::DATA_W'(-w_lim);
        end else begin
            w_clamped = pidc_pkg::DATA_W'(w_acc);
        end
    end

    // final add and saturation check
    always_comb begin
        w_drv_full = r_drv + w_prod[pidc_pkg::DRV_W-1:0];
        w_over = (w_drv_full[pidc_pkg::DRV_W-1:pidc_pkg::DATA_W-1] != '0) &&
                 (w_drv_full[pidc_pkg::DRV_W-1:pidc_pkg::DATA_W-1] != '1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pidc_pkg::ST_IDLE: if (w_in_acc) n_state = pidc_pkg::ST_STEP;
            pidc_pkg::ST_STEP: n_state = pidc_pkg::ST_INT;
            pidc_pkg::ST_INT:  n_state = pidc_pkg::ST_TI;
            pidc_pkg::ST_TI:   n_state = pidc_pkg::ST_SUM;
            pidc_pkg::ST_SUM:  n_state = pidc_pkg::ST_LO;
            pidc_pkg::ST_LO:   n_state = pidc_pkg::ST_HI;
            pidc_pkg::ST_HI:   n_state = pidc_pkg::ST_FIN;
            pidc_pkg::ST_FIN:  if (w_fin_go) n_state = pidc_pkg::ST_IDLE;
            default:           n_state = pidc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidc_pkg::ST_IDLE;
            r_integral  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pidc_pkg::ST_INT) begin
                r_integral <= w_clamped;
            end
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err <= {{EXT_W{i_reference[pidc_pkg::DATA_W-1]}}, i_reference} -
                     {{EXT_W{i_measured[pidc_pkg::DATA_W-1]}}, i_measured};
            r_err_rate <= {{EXT_W{i_reference_rate[pidc_pkg::DATA_W-1]}}, i_reference_rate} -
                          {{EXT_W{i_measured_rate[pidc_pkg::DATA_W-1]}}, i_measured_rate};
        end
        case (r_state)
            // derivative term lands first, then the integral term
            pidc_pkg::ST_TI:  r_sum <= pidc_pkg::SUM_W'(r_err) + pidc_pkg::SUM_W'(w_shr);
            pidc_pkg::ST_SUM: r_sum <= r_sum + pidc_pkg::SUM_W'(w_shr);
            pidc_pkg::ST_HI:  r_drv <= pidc_pkg::DRV_W'(w_shr);
            default: begin
                // hold
            end
        endcase
        if (w_fin_go) begin
            r_drive_sat <= w_over;
            if (!w_over) begin
                r_drive <= w_drv_full[pidc_pkg::DATA_W-1:0];
            end else if (w_drv_full[pidc_pkg::DRV_W-1]) begin
                r_drive <= {1'b1, {(pidc_pkg::DATA_W-1){1'b0}}};
            end else begin
                r_drive <= {1'b0, {(pidc_pkg::DATA_W-1){1'b1}}};
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive           = r_drive;
    assign o_drive_saturated = r_drive_sat;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == pidc_pkg::ST_STEP))
        else $error("accepted beat did not start the sequence");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == pidc_pkg::ST_FIN))
        else $error("result valid raised outside the final step");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> (o_out_valid && (r_state == pidc_pkg::ST_IDLE)))
        else $error("final step did not load the result and return to idle");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_saturated) |->
            ((o_drive == 32'sh7fffffff) || (o_drive == 32'sh80000000)))
        else $error("saturated drive is not at a rail");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for pid_with_integral_clamp_unit: a directed table, then random samples.
// Predicts drive and saturation per accepted sample with its own PID model of the control tick.
// Depends on pidc_pkg and the RTL of pid_with_integral_clamp_unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_AT       = 250;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 150;
    localparam int WIDE_W        = 96;

    localparam logic [pidc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_5 = 3'd5;
    localparam logic [pidc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [pidc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

    localparam logic signed [pidc_pkg::DATA_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [pidc_pkg::DATA_W-1:0] Q16_MIN = 32'sh8000_0000;
    localparam logic signed [pidc_pkg::DATA_W-1:0] Q16_ONE = 32'sh0001_0000;

    localparam logic signed [WIDE_W-1:0] DRIVE_TOP    = 96'sh7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] DRIVE_BOTTOM = -96'sh8000_0000;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;
    typedef enum logic [1:0] {CFG_MIXED, CFG_LOW_END, CFG_HIGH_END} t_cfg_style;

    typedef struct packed {
        logic signed [pidc_pkg::DATA_W-1:0] drive;
        logic                               sat;
    } t_drive_out;

    typedef struct packed {
        t_row_kind                          kind;
        logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index;
        logic [pidc_pkg::CFG_DAT_W-1:0]     cfg_data;
        logic signed [pidc_pkg::DATA_W-1:0] measured;
        logic signed [pidc_pkg::DATA_W-1:0] measured_rate;
        logic signed [pidc_pkg::DATA_W-1:0] target;
        logic signed [pidc_pkg::DATA_W-1:0] target_rate;
        logic                               typed;
        t_drive_out                         known;
    } t_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [pidc_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [pidc_pkg::CFG_DAT_W-1:0]     i_cfg_data;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic signed [pidc_pkg::DATA_W-1:0] i_measured;
    logic signed [pidc_pkg::DATA_W-1:0] i_measured_rate;
    logic signed [pidc_pkg::DATA_W-1:0] i_reference;
    logic signed [pidc_pkg::DATA_W-1:0] i_reference_rate;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic signed [pidc_pkg::DATA_W-1:0] o_drive;
    logic                               o_drive_saturated;

    pid_with_integral_clamp_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_measured        (i_measured),
        .i_measured_rate   (i_measured_rate),
        .i_reference       (i_reference),
        .i_reference_rate  (i_reference_rate),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_drive           (o_drive),
        .o_drive_saturated (o_drive_saturated)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // controller shadow: settings and integral as the block should hold them
    pidc_pkg::t_cfg                     shadow;
    logic signed [pidc_pkg::DATA_W-1:0] ctl_integral;

    t_row       offered_q[$];
    t_drive_out drive_expect_q[$];
    int         mismatches    = 0;
    int         results_taken = 0;
    int         quiet_cycles  = 0;
    int         burst_left    = 0;
    logic       offering      = 1'b0;

    function automatic t_drive_out pid_tick(input logic signed [pidc_pkg::DATA_W-1:0] meas,
                                            input logic signed [pidc_pkg::DATA_W-1:0] meas_rate,
                                            input logic signed [pidc_pkg::DATA_W-1:0] target,
                                            input logic signed [pidc_pkg::DATA_W-1:0] target_rate);
        logic signed [WIDE_W-1:0] err, err_rate, acc, bound, sum, drv, kp, ki, kd, tick;
        t_drive_out               res;
        kp       = $signed(shadow.gain_p);
        ki       = $signed(shadow.gain_i);
        kd       = $signed(shadow.gain_d);
        tick     = shadow.tick_period;
        bound    = shadow.integral_limit;
        err      = target - meas;
        err_rate = target_rate - meas_rate;
        acc      = ctl_integral + ((err * tick) >>> pidc_pkg::FRAC_W);
        if (acc > bound) acc = bound;
        if (acc < -bound) acc = -bound;
        ctl_integral = acc[pidc_pkg::DATA_W-1:0];
        sum = err + ((ki * acc) >>> pidc_pkg::FRAC_W) + ((kd * err_rate) >>> pidc_pkg::FRAC_W);
        drv = (kp * sum) >>> pidc_pkg::FRAC_W;
        res.sat = 1'b1;
        if (drv > DRIVE_TOP) res.drive = Q16_MAX;
        else if (drv < DRIVE_BOTTOM) res.drive = Q16_MIN;
        else begin
            res.drive = drv[pidc_pkg::DATA_W-1:0];
            res.sat   = 1'b0;
        end
        return res;
    endfunction

    function automatic t_row cfg_row(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [pidc_pkg::CFG_DAT_W-1:0] data);
        t_row row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.cfg_index = idx;
        row.cfg_data  = data;
        return row;
    endfunction

    function automatic t_row sample_row(input logic signed [pidc_pkg::DATA_W-1:0] meas,
                                        input logic signed [pidc_pkg::DATA_W-1:0] meas_rate,
                                        input logic signed [pidc_pkg::DATA_W-1:0] target,
                                        input logic signed [pidc_pkg::DATA_W-1:0] target_rate);
        t_row row;
        row               = '0;
        row.kind          = ROW_SAMPLE;
        row.measured      = meas;
        row.measured_rate = meas_rate;
        row.target        = target;
        row.target_rate   = target_rate;
        return row;
    endfunction

    function automatic t_row known_row(input logic signed [pidc_pkg::DATA_W-1:0] meas,
                                       input logic signed [pidc_pkg::DATA_W-1:0] target,
                                       input logic signed [pidc_pkg::DATA_W-1:0] drive,
                                       input logic                               sat);
        t_row row;
        row             = sample_row(meas, '0, target, '0);
        row.typed       = 1'b1;
        row.known.drive = drive;
        row.known.sat   = sat;
        return row;
    endfunction

    function automatic logic signed [pidc_pkg::DATA_W-1:0] pick_q16();
        logic signed [19:0] near;
        near = 20'($urandom);
        case ($urandom_range(0, 7))
            0:       return Q16_MAX;
            1:       return Q16_MIN;
            2, 3, 4: return near;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [pidc_pkg::CFG_DAT_W-1:0] pick_gain();
        logic signed [pidc_pkg::GAIN_W-1:0] g;
        logic signed [19:0]                 near;
        near = 20'($urandom);
        if ($urandom_range(0, 3) == 0) g = 24'($urandom);
        else g = 24'sh01_0000 + near;
        // upper data bits are unused by gain registers; toggle them anyway
        return {7'($urandom), g};
    endfunction

    function automatic logic [pidc_pkg::CFG_DAT_W-1:0] pick_limit();
        if ($urandom_range(0, 3) == 0) return 31'($urandom);
        return 31'($urandom_range(0, 32'h0040_0000));
    endfunction

    task automatic cfg_write(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pidc_pkg::CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pidc_pkg::CFG_GAIN_P: shadow.gain_p         = data[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::CFG_GAIN_I: shadow.gain_i         = data[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::CFG_GAIN_D: shadow.gain_d         = data[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::CFG_LIMIT:  shadow.integral_limit = data[pidc_pkg::LIMIT_W-1:0];
            pidc_pkg::CFG_TICK:   shadow.tick_period    = data[pidc_pkg::TICK_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // drop valid, wait out every pending result, then let the pipeline go quiet
    task automatic settle();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (offered_q.size() != 0 || drive_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sample(input t_row row);
        int gap;
        offered_q.push_back(row);
        i_in_valid       <= 1'b1;
        i_measured       <= row.measured;
        i_measured_rate  <= row.measured_rate;
        i_reference      <= row.target;
        i_reference_rate <= row.target_rate;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(0, 15);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic load_settings(input t_cfg_style style);
        logic [pidc_pkg::CFG_DAT_W-1:0] gp, gi, gd, lim, tick, junk;
        gp   = pick_gain();
        gi   = pick_gain();
        gd   = pick_gain();
        lim  = pick_limit();
        tick = {15'($urandom), 16'($urandom)};
        junk = 31'($urandom);
        if (style == CFG_LOW_END) begin
            gp   = 31'h0080_0000;
            gi   = 31'h0080_0000;
            gd   = 31'h0080_0000;
            lim  = 31'h7FFF_FFFF;
            tick = 31'h0000_FFFF;
        end else if (style == CFG_HIGH_END) begin
            gp   = 31'h007F_FFFF;
            gi   = 31'h007F_FFFF;
            gd   = 31'h007F_FFFF;
            lim  = '0;
            tick = 31'd1;
        end
        settle();
        cfg_write(pidc_pkg::CFG_GAIN_P, gp);
        cfg_write(pidc_pkg::CFG_GAIN_I, gi);
        cfg_write(pidc_pkg::CFG_GAIN_D, gd);
        cfg_write(pidc_pkg::CFG_LIMIT, lim);
        cfg_write(pidc_pkg::CFG_TICK, tick);
        case ($urandom_range(0, 2))
            0:       cfg_write(CFG_UNUSED_5, junk);
            1:       cfg_write(CFG_UNUSED_6, junk);
            default: cfg_write(CFG_UNUSED_7, junk);
        endcase
    endtask

    // predict on every accepted input beat
    always @(posedge i_clk) begin
        t_row       sent;
        t_drive_out want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sent = offered_q.pop_front();
            want = pid_tick(i_measured, i_measured_rate, i_reference, i_reference_rate);
            if (sent.typed) want = sent.known;
            drive_expect_q.push_back(want);
        end
    end

    always @(posedge i_clk) begin
        t_drive_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_taken <= results_taken + 1;
            if (drive_expect_q.size() == 0) begin
                $error("drive beat with no expectation waiting: drive %0d", o_drive);
                mismatches++;
            end else begin
                want = drive_expect_q.pop_front();
                if (o_drive !== want.drive) begin
                    $error("drive: expected %0d, got %0d", want.drive, o_drive);
                    mismatches++;
                end
                if (o_drive_saturated !== want.sat) begin
                    $error("drive_saturated: expected %0b, got %0b", want.sat, o_drive_saturated);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall patterns, plus one long hold-off to back up the input
    initial begin : result_sink
        int   seg_len;
        int   mode;
        logic held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(1, 40);
            repeat (seg_len) begin
                @(posedge i_clk);
                if (!held && results_taken >= HOLD_AT) begin
                    held = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end else begin
                    case (mode)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                        2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                        default: i_out_ready <= ~i_out_ready;
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        t_row       plan[$];
        t_cfg_style style;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_measured       <= '0;
        i_measured_rate  <= '0;
        i_reference      <= '0;
        i_reference_rate <= '0;
        shadow       = '{pidc_pkg::GAIN_P_RST, '0, '0, '0, pidc_pkg::TICK_RST};
        ctl_integral = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unity outer gain, no I or D, zero limit, so drive is the error
        plan.push_back(known_row('0, '0, '0, 1'b0));
        plan.push_back(known_row(Q16_MIN, Q16_MAX, Q16_MAX, 1'b1));
        plan.push_back(known_row(Q16_MAX, Q16_MIN, Q16_MIN, 1'b1));
        plan.push_back(known_row(32'sh0003_0000, 32'sh0005_0000, 32'sh0002_0000, 1'b0));
        plan.push_back(sample_row('0, Q16_MIN, '0, Q16_MAX));
        plan.push_back(known_row(-32'sd1, Q16_MAX, Q16_MAX, 1'b1));
        plan.push_back(known_row(32'sd1, Q16_MIN, Q16_MIN, 1'b1));
        plan.push_back(known_row('0, Q16_MIN, Q16_MIN, 1'b0));
        // writes to unused indexes must not land anywhere
        plan.push_back(cfg_row(CFG_UNUSED_5, '1));
        plan.push_back(cfg_row(CFG_UNUSED_6, '1));
        plan.push_back(cfg_row(CFG_UNUSED_7, '1));
        plan.push_back(known_row(Q16_ONE, '0, -Q16_ONE, 1'b0));
        // integral runs into its bound
        plan.push_back(cfg_row(pidc_pkg::CFG_GAIN_I, 31'h0001_0000));
        plan.push_back(cfg_row(pidc_pkg::CFG_LIMIT, 31'h0001_0000));
        plan.push_back(sample_row('0, '0, 32'sh0100_0000, '0));
        plan.push_back(sample_row('0, '0, 32'sh0100_0000, '0));
        // zero tick period holds the integral, a lowered limit clamps it
        plan.push_back(cfg_row(pidc_pkg::CFG_TICK, '0));
        plan.push_back(sample_row('0, '0, 32'sh0010_0000, '0));
        plan.push_back(cfg_row(pidc_pkg::CFG_LIMIT, 31'h0000_0100));
        plan.push_back(sample_row('0, '0, '0, '0));
        // negative and extreme gains
        plan.push_back(cfg_row(pidc_pkg::CFG_GAIN_D, 31'h007F_FFFF));
        plan.push_back(cfg_row(pidc_pkg::CFG_GAIN_P, 31'h0080_0000));
        plan.push_back(cfg_row(pidc_pkg::CFG_TICK, 31'h0000_FFFF));
        plan.push_back(sample_row('0, Q16_MIN, '0, Q16_MAX));
        plan.push_back(sample_row('0, Q16_MAX, '0, Q16_MIN));
        plan.push_back(cfg_row(pidc_pkg::CFG_GAIN_I, 31'h0080_0000));
        plan.push_back(cfg_row(pidc_pkg::CFG_LIMIT, 31'h7FFF_FFFF));
        plan.push_back(sample_row(Q16_MAX, '0, Q16_MIN, '0));
        plan.push_back(sample_row(Q16_MIN, '0, Q16_MAX, '0));
        plan.push_back(cfg_row(pidc_pkg::CFG_GAIN_D, 31'h0080_0000));
        plan.push_back(cfg_row(pidc_pkg::CFG_GAIN_P, 31'h007F_FFFF));
        plan.push_back(sample_row(Q16_MAX, Q16_MAX, Q16_MIN, Q16_MIN));
        plan.push_back(sample_row(32'sh1234_5678, -32'sh0000_9ABC, 32'sh0765_4321, 32'sh0002_0000));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle();
                cfg_write(plan[i].cfg_index, plan[i].cfg_data);
            end else begin
                send_sample(plan[i]);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            style = (phase == 1) ? CFG_LOW_END : (phase == 3) ? CFG_HIGH_END : CFG_MIXED;
            load_settings(style);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) == 0) settle();
                send_sample(sample_row(pick_q16(), pick_q16(), pick_q16(), pick_q16()));
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pidc_pkg.sv
rtl/core/pidc_cfg.sv
rtl/core/pidc_mul.sv
rtl/core/pid_with_integral_clamp_unit.sv
tb/tb.sv
